// ===== sv/assert_macros.svh =====
// Concurrent assertion macros shared by the date string validator RTL.
// Assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== sv/dsv_pkg.sv =====
// Types, constants and calendar functions of the date string validator.
// No dependencies; used by dsv_parse, dsv_check and date_string_validator.
package dsv_pkg;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;

	localparam logic [2:0] DM_DIGITS_MAX   = 3'd2;
	localparam logic [2:0] YEAR_DIGITS_MAX = 3'd4;
	localparam logic [2:0] YEAR_DIGITS_MIN = 3'd2;

	localparam logic [13:0] TWO_DIGIT_MAX = 14'd99;
	localparam logic [13:0] YEAR_BASE     = 14'd2000;
	localparam logic [6:0]  MONTH_MAX     = 7'd12;
	localparam logic [4:0]  FEB_LEAP_DAYS = 5'd29;
	localparam logic [4:0]  FEB_DAYS      = 5'd28;
	localparam logic [6:0]  FEBRUARY      = 7'd2;
	localparam logic [6:0]  JULY          = 7'd7;

	typedef enum logic [1:0] {
		FIELD_DAY,
		FIELD_MONTH,
		FIELD_YEAR
	} field_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_string;
	} in_t;

	typedef struct packed {
		logic        date_valid;
		logic [6:0]  day_value;
		logic [6:0]  month_value;
		logic [13:0] full_year;
	} out_t;

	typedef struct packed {
		logic             format_error;
		field_t           field;
		logic [2:0]       digit_count;
		logic [6:0]       day_acc;
		logic [6:0]       month_acc;
		logic [13:0]      year_acc;
		logic [3:0][3:0]  year_digits;
	} snap_t;

	function automatic logic [4:0] month_length(input logic [6:0] m, input logic leap);
		logic [4:0] len;
		if (m <= JULY) begin
			if (m == FEBRUARY)
				len = leap ? FEB_LEAP_DAYS : FEB_DAYS;
			else
				len = 5'd30 + {4'd0, m[0]};
		end else begin
			len = 5'd31 - {4'd0, m[0]};
		end
		return len;
	endfunction

	// Leap test from the last four decimal digits; two-digit years land in 20xx.
	function automatic logic is_leap(input logic [3:0][3:0] dg);
		logic [4:0] hi;
		logic [4:0] lo;
		hi = {dg[3], 1'b0} + {1'b0, dg[2]};
		lo = {dg[1], 1'b0} + {1'b0, dg[0]};
		if (dg[1] == 4'd0 && dg[0] == 4'd0)
			return hi[1:0] == 2'd0;
		return lo[1:0] == 2'd0;
	endfunction

endpackage

// ===== sv/date_string_validator.sv =====
// Top level of the date string validator: input register, parser, check, result register.
// Depends on dsv_pkg, dsv_parse, dsv_check and assert_macros.svh.
//
//  channel  | signals                                   | item
//  ---------+-------------------------------------------+------------------------------
//  char     | char_valid, char_ready, char_item         | one ASCII character + last flag
//  result   | result_valid, result_ready, result_item   | validity and parsed d/m/y
//
// One character is taken per cycle while char_ready is high. After its final
// character is accepted, a result passes the input register, the snapshot register
// and the result register. Reset clears all parse state and empties the pipeline.
// A stalled result holds its stage; characters that do not end a string keep
// flowing, and char_ready drops only while a final character waits behind a full
// snapshot register.
`include "assert_macros.svh"
module date_string_validator (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          char_valid,
	output logic          char_ready,
	input  dsv_pkg::in_t  char_item,
	output logic          result_valid,
	input  logic          result_ready,
	output dsv_pkg::out_t result_item
);
	import dsv_pkg::*;

	in_t   item_s1;
	logic  valid_s1;
	snap_t snap_s2;
	logic  valid_s2;
	out_t  result_q;
	logic  result_valid_q;

	snap_t nxt;
	out_t  checked;
	logic  out_free;
	logic  s2_free;
	logic  s1_take;
	logic  s1_free;

	assign out_free   = !result_valid_q || result_ready;
	assign s2_free    = !valid_s2 || out_free;
	assign s1_take    = valid_s1 && (!item_s1.end_of_string || s2_free);
	assign s1_free    = !valid_s1 || s1_take;
	assign char_ready = s1_free;

	dsv_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (s1_take),
		.item   (item_s1),
		.nxt    (nxt)
	);

	dsv_check u_check (
		.snap   (snap_s2),
		.result (checked)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (s1_free)
				valid_s1 <= char_valid;
			if (s2_free)
				valid_s2 <= s1_take && item_s1.end_of_string;
			if (out_free)
				result_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && char_valid)
			item_s1 <= char_item;
		if (s2_free && s1_take && item_s1.end_of_string)
			snap_s2 <= nxt;
		if (out_free && valid_s2)
			result_q <= checked;
	end

	assign result_valid = result_valid_q;
	assign result_item  = result_q;

	`ASSERT_PROP(a_month_range, clk, arst_n,
		result_valid && result_item.date_valid |->
			result_item.month_value >= 7'd1 && result_item.month_value <= MONTH_MAX)
	`ASSERT_PROP(a_day_range, clk, arst_n,
		result_valid && result_item.date_valid |->
			result_item.day_value >= 7'd1 && result_item.day_value <= 7'd31)
	`ASSERT_NEVER(a_year_range, clk, arst_n,
		result_valid && result_item.date_valid && result_item.full_year < 14'd100)

endmodule

// ===== sv/dsv_parse.sv =====
// Field parser: holds the per-string state and folds in one character per item.
// Depends on dsv_pkg.
module dsv_parse (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          take,
	input  dsv_pkg::in_t  item,
	output dsv_pkg::snap_t nxt
);
	import dsv_pkg::*;

	snap_t state_q;
	logic  is_digit;
	logic  over;
	logic [3:0] dig;

	assign is_digit = (item.char_code >= CHAR_ZERO) && (item.char_code <= CHAR_NINE);
	assign dig      = item.char_code[3:0];
	assign over     = (state_q.field == FIELD_YEAR) ? (state_q.digit_count >= YEAR_DIGITS_MAX)
	                                                : (state_q.digit_count >= DM_DIGITS_MAX);

	always_comb begin
		nxt = state_q;
		if (is_digit) begin
			if (over) begin
				nxt.format_error = 1'b1;
			end else begin
				case (state_q.field)
					FIELD_DAY: begin
						nxt.day_acc = {state_q.day_acc[3:0], 3'b0}
							+ {state_q.day_acc[5:0], 1'b0} + {3'd0, dig};
					end
					FIELD_MONTH: begin
						nxt.month_acc = {state_q.month_acc[3:0], 3'b0}
							+ {state_q.month_acc[5:0], 1'b0} + {3'd0, dig};
					end
					default: begin
						nxt.year_acc = {state_q.year_acc[10:0], 3'b0}
							+ {state_q.year_acc[12:0], 1'b0} + {10'd0, dig};
						nxt.year_digits = {state_q.year_digits[2:0], dig};
					end
				endcase
				nxt.digit_count = state_q.digit_count + 3'd1;
			end
		end else if (item.char_code == CHAR_SLASH) begin
			if (state_q.field == FIELD_YEAR) begin
				nxt.format_error = 1'b1;
			end else begin
				if (state_q.digit_count < 3'd1 || state_q.digit_count > DM_DIGITS_MAX)
					nxt.format_error = 1'b1;
				nxt.field       = (state_q.field == FIELD_DAY) ? FIELD_MONTH : FIELD_YEAR;
				nxt.digit_count = 3'd0;
			end
		end else begin
			nxt.format_error = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (take) begin
			if (item.end_of_string)
				state_q <= '0;
			else
				state_q <= nxt;
		end
	end

endmodule

// ===== sv/dsv_check.sv =====
// Final date checks: field shape, year base, leap rule, month and day ranges.
// Depends on dsv_pkg.
module dsv_check (
	input  dsv_pkg::snap_t snap,
	output dsv_pkg::out_t  result
);
	import dsv_pkg::*;

	logic       leap;
	logic [4:0] mlen;
	logic       shape_ok;
	logic       range_ok;

	assign leap     = is_leap(snap.year_digits);
	assign mlen     = month_length(snap.month_acc, leap);
	assign shape_ok = !snap.format_error && (snap.field == FIELD_YEAR)
		&& (snap.digit_count == YEAR_DIGITS_MIN || snap.digit_count == YEAR_DIGITS_MAX);
	assign range_ok = (snap.month_acc >= 7'd1) && (snap.month_acc <= MONTH_MAX)
		&& (snap.day_acc >= 7'd1) && (snap.day_acc <= {2'd0, mlen});

	always_comb begin
		result.date_valid  = shape_ok && range_ok;
		result.day_value   = snap.day_acc;
		result.month_value = snap.month_acc;
		result.full_year   = (snap.year_acc <= TWO_DIGIT_MAX) ? snap.year_acc + YEAR_BASE
		                                                      : snap.year_acc;
	end

endmodule
